>>> rtl/kns_pkg.sv
// Shared constants, types and helper functions for the k-nearest sample select block.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package kns_pkg;

	localparam int LIST_DEPTH = 8;
	localparam int COORD_BITS = 12;

	localparam int IN_COORD_W = 12;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 3 * CHAN_W;
	localparam int CFG_W      = 7;
	localparam int RANK_W     = 6;
	localparam int OUT_DIST_W = 25;

	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = SQ_W + 1;
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	localparam logic [CFG_W-1:0] NEIGHBOR_COUNT_RESET = 7'd4;

	// Sort key: distance first, then the packed colour, so a plain unsigned
	// compare of the whole vector gives the required ordering.
	typedef struct packed {
		logic [DIST_W-1:0]  dsq;
		logic [COLOR_W-1:0] color;
	} key_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		key_t key;
	} sample_t;

	typedef struct packed {
		logic load;
		logic occupied;
	} cell_ctrl_t;

	function automatic logic [COORD_BITS-1:0] coord_of(input logic [IN_COORD_W-1:0] v);
		logic [IN_COORD_W+COORD_BITS-1:0] w;
		w = {{COORD_BITS{1'b0}}, v};
		return w[COORD_BITS-1:0];
	endfunction

endpackage

>>> rtl/kns_dist.sv
// Three-stage squared-distance pipeline: absolute differences, squares, sum.
// Depends on kns_pkg for widths and the sample_t type.
module kns_dist (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [kns_pkg::IN_COORD_W-1:0]  query_x,
	input  logic [kns_pkg::IN_COORD_W-1:0]  query_y,
	input  logic [kns_pkg::IN_COORD_W-1:0]  sample_x,
	input  logic [kns_pkg::IN_COORD_W-1:0]  sample_y,
	input  logic [kns_pkg::COLOR_W-1:0]     color,
	input  logic                            first,
	input  logic                            last,
	output kns_pkg::sample_t                sample,
	output logic                            last_busy
);

	logic [kns_pkg::COORD_BITS-1:0] qx, qy, sx, sy;
	logic [kns_pkg::COORD_BITS-1:0] dx_s1, dy_s1;
	logic [kns_pkg::SQ_W-1:0]       sqx_s2, sqy_s2;
	logic [kns_pkg::DIST_W-1:0]     dist_s3;
	logic [kns_pkg::COLOR_W-1:0]    color_s1, color_s2, color_s3;
	logic                           v_s1, v_s2, v_s3;
	logic                           first_s1, first_s2, first_s3;
	logic                           last_s1, last_s2, last_s3;

	assign qx = kns_pkg::coord_of(query_x);
	assign qy = kns_pkg::coord_of(query_y);
	assign sx = kns_pkg::coord_of(sample_x);
	assign sy = kns_pkg::coord_of(sample_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= (qx > sx) ? (qx - sx) : (sx - qx);
		dy_s1    <= (qy > sy) ? (qy - sy) : (sy - qy);
		color_s1 <= color;
		first_s1 <= first;
		last_s1  <= last;

		sqx_s2   <= kns_pkg::SQ_W'(dx_s1) * kns_pkg::SQ_W'(dx_s1);
		sqy_s2   <= kns_pkg::SQ_W'(dy_s1) * kns_pkg::SQ_W'(dy_s1);
		color_s2 <= color_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;

		dist_s3  <= kns_pkg::DIST_W'(sqx_s2) + kns_pkg::DIST_W'(sqy_s2);
		color_s3 <= color_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
	end

	assign sample.valid     = v_s3;
	assign sample.first     = first_s3;
	assign sample.last      = last_s3;
	assign sample.key.dsq   = dist_s3;
	assign sample.key.color = color_s3;

	assign last_busy = (v_s1 & last_s1) | (v_s2 & last_s2) | (v_s3 & last_s3);

endmodule

>>> rtl/kns_cell.sv
// One slot of the sorted neighbour list: compares the new key against its own
// and either keeps, takes the new key or takes its left neighbour's key. Uses kns_pkg.
module kns_cell (
	input  logic                clk,
	input  kns_pkg::cell_ctrl_t ctl,
	input  kns_pkg::key_t       new_key,
	input  kns_pkg::key_t       left_key,
	input  logic                left_after,
	output kns_pkg::key_t       key,
	output logic                after
);

	kns_pkg::key_t key_q;

	// An empty slot, or one holding a strictly greater key, lies at or after
	// the insertion point.
	assign after = !ctl.occupied || (key_q > new_key);
	assign key   = key_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (after && !left_after) begin
				key_q <= new_key;
			end else if (left_after) begin
				key_q <= left_key;
			end
		end
	end

endmodule

>>> rtl/k_nearest_sample_select_core.sv
// The first result of a set is offered once its last_of_set sample has passed the distance
// pipeline, the list insertion and the output register. Throughput: one sample per cycle
// while no set is closing; a last_of_set sample holds the input off while in the pipeline and
// until its last neighbour is loaded, stalls included: the cell chain has one read-out port.
// Reset (asynchronous, active low): list empty, neighbour count 4, pipelines idle.
// The list contents themselves are not reset; only slots below the fill count are read.
module k_nearest_sample_select_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kns_pkg::CFG_W-1:0]          cfg_data,
	// sample channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [kns_pkg::IN_COORD_W-1:0]     query_x,
	input  logic [kns_pkg::IN_COORD_W-1:0]     query_y,
	input  logic [kns_pkg::IN_COORD_W-1:0]     sample_x,
	input  logic [kns_pkg::IN_COORD_W-1:0]     sample_y,
	input  logic [kns_pkg::CHAN_W-1:0]         chan_zero,
	input  logic [kns_pkg::CHAN_W-1:0]         chan_one,
	input  logic [kns_pkg::CHAN_W-1:0]         chan_two,
	input  logic                               first_of_set,
	input  logic                               last_of_set,
	// neighbour channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [kns_pkg::RANK_W-1:0]         rank,
	output logic [kns_pkg::OUT_DIST_W-1:0]     distance_sq,
	output logic [kns_pkg::CHAN_W-1:0]         out_chan_zero,
	output logic [kns_pkg::CHAN_W-1:0]         out_chan_one,
	output logic [kns_pkg::CHAN_W-1:0]         out_chan_two,
	output logic                               final_entry
);

	// Configuration register; cfg_ready is tied high. Writes are only to be made while the block
	// is idle; the block itself does not enforce this.
	logic [kns_pkg::CFG_W-1:0] count_q;
	logic [kns_pkg::CNT_W-1:0] eff_k;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= kns_pkg::NEIGHBOR_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// The effective k saturates at the list depth.
	assign eff_k = (count_q > kns_pkg::CFG_W'(kns_pkg::LIST_DEPTH)) ?
		kns_pkg::CNT_W'(kns_pkg::LIST_DEPTH) : kns_pkg::CNT_W'(count_q);

	// Distance pipeline. A sample entering it is accepted whenever no closing sample
	// is in flight and the list is not being read out.
	logic             in_take;
	logic             last_busy;
	logic             emit_active_q;
	kns_pkg::sample_t smp;

	assign in_ready = !last_busy && !emit_active_q;
	assign in_take  = in_valid && in_ready;

	kns_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_take),
		.query_x   (query_x),
		.query_y   (query_y),
		.sample_x  (sample_x),
		.sample_y  (sample_y),
		.color     ({chan_zero, chan_one, chan_two}),
		.first     (first_of_set),
		.last      (last_of_set),
		.sample    (smp),
		.last_busy (last_busy)
	);

	// Fill count as seen by the arriving sample: cleared by first_of_set, then cut
	// to the current k in case the count was lowered within a set.
	logic [kns_pkg::CNT_W-1:0] held_q;
	logic [kns_pkg::CNT_W-1:0] held_start;
	logic [kns_pkg::CNT_W-1:0] held_cut;
	logic [kns_pkg::CNT_W-1:0] held_next;

	assign held_start = smp.first ? '0 : held_q;
	assign held_cut   = (held_start > eff_k) ? eff_k : held_start;

	// The chain of cells. Every cell sees the new key; each one passes its key and
	// its "at or after the insertion point" flag to its right-hand neighbour, so the
	// whole insertion, shift included, is registered at the same clock edge in every cell.
	kns_pkg::key_t                  cell_key [kns_pkg::LIST_DEPTH];
	logic [kns_pkg::LIST_DEPTH-1:0] cell_after;
	logic [kns_pkg::LIST_DEPTH-1:0] below_k;

	for (genvar i = 0; i < kns_pkg::LIST_DEPTH; i++) begin : g_cell
		localparam logic [kns_pkg::CNT_W-1:0] SLOT = kns_pkg::CNT_W'(i);

		kns_pkg::cell_ctrl_t ctl;
		kns_pkg::key_t       left_key;
		logic                left_after;

		assign ctl.load     = smp.valid;
		assign ctl.occupied = SLOT < held_cut;
		assign below_k[i]   = SLOT < eff_k;

		if (i == 0) begin : g_head
			assign left_key   = smp.key;
			assign left_after = 1'b0;
		end else begin : g_body
			assign left_key   = cell_key[i-1];
			assign left_after = cell_after[i-1];
		end

		kns_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_key    (smp.key),
			.left_key   (left_key),
			.left_after (left_after),
			.key        (cell_key[i]),
			.after      (cell_after[i])
		);
	end

	// The sample is kept when its insertion point lies within the first k slots.
	// Slots from k onwards may take shifted keys, but they are never read before
	// being written again.
	logic ins_ok;

	assign ins_ok    = |(cell_after & below_k);
	assign held_next = (ins_ok && (held_cut < eff_k)) ?
		kns_pkg::CNT_W'(held_cut + 1'b1) : held_cut;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (smp.valid) begin
			held_q <= held_next;
		end
	end

	// Read-out. After a closing sample has been inserted the list is walked from
	// rank 0 into the output register, one entry per cycle while the register is
	// free or being emptied. The input stays closed until the last entry has been
	// loaded, so the list does not move underneath the walk.
	logic [kns_pkg::CNT_W-1:0] emit_idx_q;
	logic                      out_valid_q;
	logic                      slot_free;
	logic                      emit_load;
	logic                      emit_last;
	kns_pkg::key_t             emit_key;

	assign slot_free = !out_valid_q || out_ready;
	assign emit_load = emit_active_q && slot_free;
	assign emit_last = kns_pkg::CNT_W'(emit_idx_q + 1'b1) == held_q;
	assign emit_key  = cell_key[emit_idx_q[kns_pkg::IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_active_q <= 1'b0;
			emit_idx_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (smp.valid && smp.last) begin
				emit_active_q <= held_next != '0;
				emit_idx_q    <= '0;
			end else if (emit_load) begin
				emit_active_q <= !emit_last;
				emit_idx_q    <= kns_pkg::CNT_W'(emit_idx_q + 1'b1);
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register; it only changes when a new entry is loaded.
	logic [kns_pkg::RANK_W-1:0]     rank_q;
	logic [kns_pkg::OUT_DIST_W-1:0] dist_q;
	logic [kns_pkg::COLOR_W-1:0]    color_q;
	logic                           final_q;

	always_ff @(posedge clk) begin
		if (emit_load) begin
			rank_q  <= kns_pkg::RANK_W'(emit_idx_q);
			dist_q  <= kns_pkg::OUT_DIST_W'(emit_key.dsq);
			color_q <= emit_key.color;
			final_q <= emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign rank          = rank_q;
	assign distance_sq   = dist_q;
	assign out_chan_zero = color_q[3*kns_pkg::CHAN_W-1:2*kns_pkg::CHAN_W];
	assign out_chan_one  = color_q[2*kns_pkg::CHAN_W-1:kns_pkg::CHAN_W];
	assign out_chan_two  = color_q[kns_pkg::CHAN_W-1:0];
	assign final_entry   = final_q;

endmodule

>>> rtl/kns_checker.sv
// Port-level checks on the k-nearest sample select core, bound to the top level.
// Depends on kns_pkg for field widths.
module kns_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [kns_pkg::RANK_W-1:0]         rank,
	input logic [kns_pkg::OUT_DIST_W-1:0]     distance_sq,
	input logic                               final_entry
);

	// A stalled result holds its rank and distance.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(distance_sq))
		else $error("stalled neighbour transaction changed");

	// Ranks of one set follow each other without gaps.
	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_entry |=>
		!out_valid || rank == kns_pkg::RANK_W'($past(rank) + 1'b1))
		else $error("neighbour rank skipped");

	// A new set starts at rank 0.
	a_rank_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_entry |=> !out_valid || rank == '0)
		else $error("set did not start at rank 0");

	// The sample input stays closed while a set is still being read out.
	a_no_input_midset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !final_entry |-> !in_ready)
		else $error("sample taken while a set was being emitted");

endmodule

bind k_nearest_sample_select_core kns_checker u_kns_checker (.*);
